// ===== sv/symt_pkg.sv =====
// ----------------------------------------------------------------------------
// symt_pkg: symbol table shared types and constants
// Entry layouts, transfer payloads, status and function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package symt_pkg;

  localparam int TABLE_DEPTH    = 256;
  localparam int MAX_NAME_CHARS = 31;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
  localparam int SCAN_W         = (CNT_W > 9) ? CNT_W : 9;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_RELOC  = 2'd2;
  localparam logic [1:0] FUNC_FIND   = 2'd3;

  localparam logic [2:0] ST_APPENDED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_BAD_NAME  = 3'd2;
  localparam logic [2:0] ST_EXT_DEF   = 3'd3;
  localparam logic [2:0] ST_DUP_LABEL = 3'd4;
  localparam logic [2:0] ST_EXT_ENTRY = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd2;
  localparam logic [1:0] FLAG_ENTRY   = 2'd1;
  localparam logic [1:0] FLAG_EXTERN  = 2'd2;
  localparam logic [1:0] FLAG_BOTH    = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [63:0] name_word3;
    logic [5:0]  name_length;
    logic [15:0] sym_address;
    logic [1:0]  sym_kind;
    logic [1:0]  sym_flag;
    logic [15:0] offset;
    logic [8:0]  start_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  hit_index;
    logic [15:0] hit_address;
    logic [1:0]  hit_kind;
    logic [1:0]  hit_flag;
    logic [63:0] hit_name0;
    logic [63:0] hit_name1;
    logic [63:0] hit_name2;
    logic [63:0] hit_name3;
    logic [4:0]  hit_length;
  } out_t;

  typedef struct packed {
    logic [4:0]   len;
    logic [255:0] chars;
  } name_ent_t;

  typedef struct packed {
    logic [15:0] address;
    logic [1:0]  kind;
    logic [1:0]  flag;
  } attr_ent_t;

  typedef struct packed {
    logic         legal;
    logic [255:0] chars;
  } chk_t;

  typedef struct packed {
    logic [2:0] status;
    attr_ent_t  attr;
    logic       wr;
  } merge_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_letter(c) || ((c >= 8'd48) && (c <= 8'd57));
  endfunction

endpackage

`default_nettype wire

// ===== sv/symt_ram.sv =====
// ----------------------------------------------------------------------------
// symt_ram: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module symt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/symt_name_chk.sv =====
// ----------------------------------------------------------------------------
// symt_name_chk: name masking and legality check
// Clears bytes past the length and checks letter/alphanumeric rules.
// ----------------------------------------------------------------------------
`default_nettype none

module symt_name_chk
  import symt_pkg::*;
(
  input  wire logic [255:0] chars_i,
  input  wire logic [5:0]   len_i,
  output      chk_t         chk_o
);

  always_comb begin
    logic ok;
    ok = (len_i != 6'd0) && (len_i <= 6'(MAX_NAME_CHARS)) && is_letter(chars_i[7:0]);
    for (int b = 0; b < 32; b++) begin
      if (6'(b) < len_i) begin
        chk_o.chars[b*8 +: 8] = chars_i[b*8 +: 8];
        if ((b > 0) && !is_alnum(chars_i[b*8 +: 8])) begin
          ok = 1'b0;
        end
      end else begin
        chk_o.chars[b*8 +: 8] = 8'd0;
      end
    end
    chk_o.legal = ok;
  end

endmodule

`default_nettype wire

// ===== sv/symt_merge.sv =====
// ----------------------------------------------------------------------------
// symt_merge: merge rules for a name already in the table
// Resolves extern, entry and duplicate label conflicts.
// ----------------------------------------------------------------------------
`default_nettype none

module symt_merge
  import symt_pkg::*;
(
  input  wire attr_ent_t   stored_i,
  input  wire logic [15:0] address_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [1:0]  flag_i,
  output      merge_t      merge_o
);

  always_comb begin
    merge_o.status = ST_FOUND;
    merge_o.attr   = stored_i;
    merge_o.wr     = 1'b0;
    if (address_i != 16'd0) begin
      priority if (stored_i.flag == FLAG_EXTERN) begin
        merge_o.status = ST_EXT_DEF;
      end else if (stored_i.address == 16'd0) begin
        merge_o.attr.address = address_i;
        merge_o.attr.kind    = kind_i;
        merge_o.wr           = 1'b1;
      end else begin
        merge_o.status = ST_DUP_LABEL;
      end
    end else begin
      priority if ((stored_i.flag == FLAG_EXTERN) && (kind_i != KIND_UNKNOWN)) begin
        merge_o.status = ST_EXT_DEF;
      end else if ((flag_i | stored_i.flag) == FLAG_BOTH) begin
        merge_o.status = ST_EXT_ENTRY;
      end else begin
        merge_o.attr.flag = flag_i;
        merge_o.wr        = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/assembler_symbol_table_unit.sv =====
// ----------------------------------------------------------------------------
// assembler_symbol_table_unit: insertion-ordered assembler symbol table
// Insert/merge, lookup, data relocation and entry search over a RAM scan.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | in_data_i  (in_t)
// out     | output    | out_valid_o / out_stall_i| out_data_o (out_t)
//
// A transfer scans the stored entries in order (up to TABLE_DEPTH); an illegal
// insert skips the scan. The scan reads one entry per cycle
// through the registered read port of the entry RAMs.
// Relocate writes each data entry back through the write port in the cycle after its read.
// Reset empties the table; entry RAMs are not cleared.
// A stalled output holds the next result in the unit until the output frees.
// ----------------------------------------------------------------------------
`default_nettype none

module assembler_symbol_table_unit
  import symt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_stall_o,
  input  wire in_t  in_data_i,
  output      logic out_valid_o,
  input  wire logic out_stall_i,
  output      out_t out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  in_t              req_q;
  logic [SCAN_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pidx_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  out_t             res_q, res_d;
  logic             ov_q;
  out_t             out_q;

  chk_t      chk;
  name_ent_t name_rd, name_wd;
  attr_ent_t attr_rd, attr_wd;
  logic      name_we, attr_we;
  logic [IDX_W-1:0] waddr;
  merge_t    mrg;
  logic      accept, issue, hit, finish;
  logic [SCAN_W-1:0] cnt_ext;
  logic [IDX_W+7:0]  pidx_ext, cidx_ext;

  symt_name_chk u_chk (
    .chars_i({in_data_i.name_word3, in_data_i.name_word2,
              in_data_i.name_word1, in_data_i.name_word0}),
    .len_i  (in_data_i.name_length),
    .chk_o  (chk)
  );

  symt_merge u_merge (
    .stored_i (attr_rd),
    .address_i(req_q.sym_address),
    .kind_i   (req_q.sym_kind),
    .flag_i   (req_q.sym_flag),
    .merge_o  (mrg)
  );

  symt_ram #(.WIDTH($bits(name_ent_t)), .DEPTH(TABLE_DEPTH)) u_name_ram (
    .clk_i  (clk_i),
    .we_i   (name_we),
    .waddr_i(waddr),
    .wdata_i(name_wd),
    .raddr_i(idx_q[IDX_W-1:0]),
    .rdata_o(name_rd)
  );

  symt_ram #(.WIDTH($bits(attr_ent_t)), .DEPTH(TABLE_DEPTH)) u_attr_ram (
    .clk_i  (clk_i),
    .we_i   (attr_we),
    .waddr_i(waddr),
    .wdata_i(attr_wd),
    .raddr_i(idx_q[IDX_W-1:0]),
    .rdata_o(attr_rd)
  );

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cnt_ext    = SCAN_W'(cnt_q);
  assign issue      = idx_q < cnt_ext;
  assign pidx_ext   = {8'd0, pidx_q};
  assign cidx_ext   = {8'd0, cnt_q[IDX_W-1:0]};

  always_comb begin
    unique case (req_q.func)
      FUNC_INSERT, FUNC_LOOKUP: hit = pend_q && (name_rd.len == req_q.name_length[4:0]) &&
        !req_q.name_length[5] &&
        (name_rd.chars == {req_q.name_word3, req_q.name_word2,
                           req_q.name_word1, req_q.name_word0});
      FUNC_FIND:  hit = pend_q && (attr_rd.flag == FLAG_ENTRY);
      default:    hit = 1'b0;
    endcase
  end

  assign finish = (state_q == S_SCAN) && (hit || (!issue && !pend_q));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    cnt_d   = cnt_q;
    res_d   = res_q;
    name_we = 1'b0;
    attr_we = 1'b0;
    waddr   = pidx_q;
    name_wd = {req_q.name_length[4:0], req_q.name_word3, req_q.name_word2,
               req_q.name_word1, req_q.name_word0};
    attr_wd = {attr_rd.address + req_q.offset, attr_rd.kind, attr_rd.flag};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          idx_d = (in_data_i.func == FUNC_FIND) ? SCAN_W'(in_data_i.start_index) : '0;
          if ((in_data_i.func == FUNC_INSERT) && !chk.legal) begin
            res_d.status = ST_BAD_NAME;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end
        if ((req_q.func == FUNC_RELOC) && pend_q && (attr_rd.kind == KIND_DATA)) begin
          attr_we = 1'b1;
        end
        if (finish) begin
          state_d = S_DONE;
          pend_d  = 1'b0;
          res_d   = '0;
          if (hit) begin
            res_d.status      = ST_FOUND;
            res_d.hit_index   = pidx_ext[7:0];
            res_d.hit_address = attr_rd.address;
            res_d.hit_kind    = attr_rd.kind;
            res_d.hit_flag    = attr_rd.flag;
            res_d.hit_name0   = name_rd.chars[63:0];
            res_d.hit_name1   = name_rd.chars[127:64];
            res_d.hit_name2   = name_rd.chars[191:128];
            res_d.hit_name3   = name_rd.chars[255:192];
            res_d.hit_length  = name_rd.len;
            if (req_q.func == FUNC_INSERT) begin
              res_d.status      = mrg.status;
              res_d.hit_address = mrg.attr.address;
              res_d.hit_kind    = mrg.attr.kind;
              res_d.hit_flag    = mrg.attr.flag;
              attr_we           = mrg.wr;
              attr_wd           = mrg.attr;
            end
          end else begin
            unique case (req_q.func)
              FUNC_INSERT: begin
                if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
                  res_d.status = ST_FULL;
                end else begin
                  name_we           = 1'b1;
                  attr_we           = 1'b1;
                  waddr             = cnt_q[IDX_W-1:0];
                  attr_wd           = {req_q.sym_address, req_q.sym_kind, req_q.sym_flag};
                  cnt_d             = cnt_q + 1'b1;
                  res_d.status      = ST_APPENDED;
                  res_d.hit_index   = cidx_ext[7:0];
                  res_d.hit_address = req_q.sym_address;
                  res_d.hit_kind    = req_q.sym_kind;
                  res_d.hit_flag    = req_q.sym_flag;
                  res_d.hit_name0   = req_q.name_word0;
                  res_d.hit_name1   = req_q.name_word1;
                  res_d.hit_name2   = req_q.name_word2;
                  res_d.hit_name3   = req_q.name_word3;
                  res_d.hit_length  = req_q.name_length[4:0];
                end
              end
              FUNC_RELOC: res_d.status = ST_FOUND;
              default:    res_d.status = ST_NOT_FOUND;
            endcase
          end
        end
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      if ((state_q == S_DONE) && (!ov_q || !out_stall_i)) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    pidx_q <= idx_q[IDX_W-1:0];
    if (accept) begin
      req_q <= {in_data_i.func, chk.chars[63:0], chk.chars[127:64],
                chk.chars[191:128], chk.chars[255:192], in_data_i.name_length,
                in_data_i.sym_address, in_data_i.sym_kind, in_data_i.sym_flag,
                in_data_i.offset, in_data_i.start_index};
    end
    if ((state_q == S_DONE) && (!ov_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count past table depth");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("entry count moved by other than one");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("idle after accepting a transfer");
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN))
    else $error("read pending outside scan");
`endif

endmodule

`default_nettype wire
